// ===== rtl/hpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

   localparam int DW      = 64;   // register data width
   localparam int NREG    = 8;    // number of matrix registers
   localparam int AW      = 6;    // byte address width
   localparam int IDX_LSB = 3;    // registers are 8 bytes apart
   localparam int IDX_W   = 3;
   localparam int CW      = 32;   // coefficient / coordinate width
   localparam int PW      = 64;   // product width
   localparam int SW      = 66;   // sum of three products
   localparam int RW      = 67;   // row sum width
   localparam int QB      = 33;   // quotient bits kept by the divider
   localparam int ROW_LAT = 3;    // multiply, sum, shift
   localparam int DIV_LAT = QB + 2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SAT   = 2'd1;
   localparam logic [1:0] STATUS_WZERO = 2'd2;

   typedef struct packed {
      logic              mode;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [1:0]         status;
   } rsp_type;

   // coefficient matrix, [row][col]
   typedef logic [3:0][3:0][CW-1:0] coef_type;

   typedef struct packed {
      logic valid;
      logic vec;
   } ctl_type;

   typedef struct packed {
      logic valid;
      logic vec;
      logic wzero;
      logic wone;
   } flag_type;

endpackage

// ===== rtl/hpt_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_csr
// Matrix register file behind the APB port; resets to identity.
// ----------------------------------------------------------------------------
module hpt_csr import hpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [AW-1:0] paddr,
   input  logic [DW-1:0] pwdata,
   output logic [DW-1:0] prdata,
   output logic          pready,
   output coef_type      coef
);

   localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

   logic [DW-1:0]    creg_ff [NREG];
   logic [IDX_W-1:0] idx;
   logic             wr_en;

   assign idx    = paddr[IDX_LSB +: IDX_W];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = creg_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) creg_ff[i] <= '0;
         creg_ff[0] <= {{CW{1'b0}}, ONE};
         creg_ff[2] <= {ONE, {CW{1'b0}}};
         creg_ff[5] <= {{CW{1'b0}}, ONE};
         creg_ff[7] <= {ONE, {CW{1'b0}}};
      end else if (wr_en) begin
         creg_ff[idx] <= pwdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = creg_ff[2*r + c/2][(c%2)*CW +: CW];
         end
      end
   end

endmodule

// ===== rtl/hpt_rowsum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_rowsum
// Four row dot products: multiply, sum, floor shift plus translation.
// ----------------------------------------------------------------------------
module hpt_rowsum import hpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  req_type              in_req,
   input  coef_type             coef,
   output ctl_type              out_ctl,
   output logic signed [RW-1:0] out_row [4]
);

   // stage 1: products
   ctl_type              c1_ff, c1_in;
   logic signed [PW-1:0] p_ff [4][3];
   logic signed [PW-1:0] p_in [4][3];
   // stage 2: row sums of products
   ctl_type              c2_ff;
   logic signed [SW-1:0] s_ff [4];
   logic signed [SW-1:0] s_in [4];
   // stage 3: shifted, translated
   ctl_type              c3_ff;
   logic signed [RW-1:0] q_ff [4];
   logic signed [RW-1:0] q_in [4];

   logic signed [CW-1:0] v [3];
   logic signed [CW-1:0] k;
   logic signed [CW-1:0] t;
   logic signed [RW-1:0] se;

   assign c1_in.valid = in_valid;
   assign c1_in.vec   = in_req.mode;

   always_comb begin
      v[0] = in_req.in_x;
      v[1] = in_req.in_y;
      v[2] = in_req.in_z;
      k    = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            k          = coef[r][c];
            p_in[r][c] = k * v[c];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         s_in[r] = {{2{p_ff[r][0][PW-1]}}, p_ff[r][0]}
                 + {{2{p_ff[r][1][PW-1]}}, p_ff[r][1]}
                 + {{2{p_ff[r][2][PW-1]}}, p_ff[r][2]};
      end
   end

   always_comb begin
      t  = '0;
      se = '0;
      for (int r = 0; r < 4; r++) begin
         // row 3 (weight) always takes its translation; rows 0..2 not in vector mode
         t       = (r == 3 || !c2_ff.vec) ? coef[r][3] : '0;
         se      = {{(RW-SW){s_ff[r][SW-1]}}, s_ff[r]};
         // floor shift: keep the whole expression signed
         q_in[r] = (se >>> FRAC_BITS) + $signed({{(RW-CW){t[CW-1]}}, t});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else begin
         c1_ff <= c1_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      s_ff <= s_in;
      q_ff <= q_in;
   end

   assign out_ctl = c3_ff;
   assign out_row = q_ff;

endmodule

// ===== rtl/hpt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit
// per stage, truncated toward zero, with overflow detect above QB bits.
// ----------------------------------------------------------------------------
module hpt_div import hpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic signed [RW-1:0] num,
   input  logic signed [RW-1:0] den,
   output logic signed [RW-1:0] out_num,
   output logic [QB-1:0]        out_quo,
   output logic                 out_ovf,
   output logic                 out_neg
);

   localparam int NW = RW + FRAC_BITS;

   // stage A: sign and magnitude
   logic signed [RW-1:0] a_num_ff;
   logic [RW-1:0]        a_m_ff, a_d_ff;
   logic                 a_neg_ff;

   // stage B and bit stages, index 0 is stage B
   logic signed [RW-1:0] num_ff [QB+1];
   logic [RW-1:0]        r_ff   [QB+1];
   logic [RW-1:0]        d_ff   [QB+1];
   logic [QB-1:0]        q_ff   [QB+1];
   logic [QB-1:0]        nl_ff  [QB+1];
   logic                 neg_ff [QB+1];
   logic                 ovf_ff [QB+1];

   logic [NW-1:0] n;
   logic [RW-1:0] n_hi;
   logic          b_ovf_in;

   always_ff @(posedge clock) begin
      a_num_ff <= num;
      a_neg_ff <= num[RW-1] ^ den[RW-1];
      a_m_ff   <= num[RW-1] ? RW'(-num) : RW'(num);
      a_d_ff   <= den[RW-1] ? RW'(-den) : RW'(den);
   end

   always_comb begin
      n        = {a_m_ff, {FRAC_BITS{1'b0}}};
      n_hi     = RW'(n[NW-1:QB]);
      b_ovf_in = n_hi >= a_d_ff;
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= a_num_ff;
      r_ff[0]   <= b_ovf_in ? '0 : n_hi;
      d_ff[0]   <= a_d_ff;
      q_ff[0]   <= '0;
      nl_ff[0]  <= n[QB-1:0];
      neg_ff[0] <= a_neg_ff;
      ovf_ff[0] <= b_ovf_in;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_bit
      logic [RW:0]   rs;
      logic          ge;
      logic [RW-1:0] r_in;

      always_comb begin
         rs   = {r_ff[k-1], nl_ff[k-1][QB-1]};
         ge   = rs >= {1'b0, d_ff[k-1]};
         r_in = ge ? RW'(rs - {1'b0, d_ff[k-1]}) : RW'(rs);
      end

      always_ff @(posedge clock) begin
         num_ff[k] <= num_ff[k-1];
         r_ff[k]   <= r_in;
         d_ff[k]   <= d_ff[k-1];
         q_ff[k]   <= {q_ff[k-1][QB-2:0], ge};
         nl_ff[k]  <= {nl_ff[k-1][QB-2:0], 1'b0};
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign out_num = num_ff[QB];
   assign out_quo = q_ff[QB];
   assign out_ovf = ovf_ff[QB];
   assign out_neg = neg_ff[QB];

endmodule

// ===== rtl/homogeneous_point_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 fixed-point matrix times (x, y, z, 1), with homogeneous divide,
// saturation and zero-weight flagging.
// ----------------------------------------------------------------------------
//  channel   ports                          transfer
//  request   start, busy, req_data          start && !busy
//  response  rsp_strobe, rsp_data           one cycle, no backpressure
//  config    psel..pready (APB, 64-bit)     psel && penable && pwrite
//
// One transaction per cycle, fully pipelined; the divider resolves one
// quotient bit per stage over QB stages.
// Synchronous reset clears all valid bits and loads the identity matrix;
// busy is high only during reset.
// The response side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module homogeneous_point_transform import hpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [AW-1:0] paddr,
   input  logic [DW-1:0] pwdata,
   output logic [DW-1:0] prdata,
   output logic          pready
);

   localparam int LAT = ROW_LAT + DIV_LAT + 1;
   localparam logic signed [RW-1:0] W_ONE = RW'(1) << FRAC_BITS;

   typedef struct packed {
      logic [31:0] val;
      logic        sat;
   } lane_type;

   coef_type             coef;
   ctl_type              row_ctl;
   logic signed [RW-1:0] row [4];
   logic                 accept;

   // per-lane divider results
   logic signed [RW-1:0] dnum [3];
   logic [QB-1:0]        dquo [3];
   logic                 dovf [3];
   logic                 dneg [3];

   // control flags delayed alongside the divider
   flag_type fl_ff [DIV_LAT];
   flag_type fl_in;

   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign busy   = reset;
   assign accept = start && !busy;

   hpt_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   hpt_rowsum #(.FRAC_BITS(FRAC_BITS)) u_rowsum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_req   (req_data),
      .coef     (coef),
      .out_ctl  (row_ctl),
      .out_row  (row)
   );

   // one divider per coordinate, all sharing the weight row
   for (genvar i = 0; i < 3; i++) begin : g_lane
      hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .num     (row[i]),
         .den     (row[3]),
         .out_num (dnum[i]),
         .out_quo (dquo[i]),
         .out_ovf (dovf[i]),
         .out_neg (dneg[i])
      );
   end

   assign fl_in.valid = row_ctl.valid;
   assign fl_in.vec   = row_ctl.vec;
   assign fl_in.wzero = (row[3] == '0);
   assign fl_in.wone  = (row[3] == W_ONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) fl_ff[i] <= '0;
      end else begin
         fl_ff[0] <= fl_in;
         for (int i = 1; i < DIV_LAT; i++) fl_ff[i] <= fl_ff[i-1];
      end
   end

   // clamp an undivided row sum to 32 bits
   function automatic lane_type clamp_row(logic signed [RW-1:0] v);
      lane_type o;
      o.sat = !((&v[RW-1:31]) || !(|v[RW-1:31]));
      o.val = o.sat ? (v[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v[31:0];
      return o;
   endfunction

   // signed result from the divider's magnitude
   function automatic lane_type clamp_quo(logic [QB-1:0] q, logic ovf, logic neg);
      lane_type o;
      if (ovf) begin
         o.sat = 1'b1;
         o.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (!neg) begin
         o.sat = |q[QB-1:31];
         o.val = o.sat ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         // magnitude 2^31 still fits as the most negative value
         o.sat = (|q[QB-1:32]) || (q[31] && (|q[30:0]));
         o.val = o.sat ? 32'h8000_0000 : 32'(-q[31:0]);
      end
      return o;
   endfunction

   always_comb begin
      lane_type   ln [3];
      logic       any_sat;
      flag_type   f;
      f       = fl_ff[DIV_LAT-1];
      any_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (f.vec || f.wone) begin
            ln[i] = clamp_row(dnum[i]);
         end else if (f.wzero) begin
            // zero weight: saturate toward the undivided sign
            ln[i].sat = 1'b0;
            ln[i].val = dnum[i][RW-1] ? 32'h8000_0000
                      : (dnum[i] != '0) ? 32'h7FFF_FFFF : 32'h0;
         end else begin
            ln[i] = clamp_quo(dquo[i], dovf[i], dneg[i]);
         end
         any_sat = any_sat | ln[i].sat;
      end
      rsp_data_in.out_x = ln[0].val;
      rsp_data_in.out_y = ln[1].val;
      rsp_data_in.out_z = ln[2].val;
      if (!f.vec && f.wzero)  rsp_data_in.status = STATUS_WZERO;
      else if (any_sat)       rsp_data_in.status = STATUS_SAT;
      else                    rsp_data_in.status = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= fl_ff[DIV_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every response comes from an earlier accepted transaction
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("response without matching request");

   // zero-weight status only for point-mode transactions
   a_wzero_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_WZERO) |-> $past(!req_data.mode, LAT))
      else $error("zero-weight status on a vector transaction");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for homogeneous_point_transform: drives coordinate
// transactions with random gaps over several matrix settings, predicts each
// transformed point and compares it field by field with the response strobe.
// ----------------------------------------------------------------------------
module tb;
   import hpt_pkg::*;

   localparam int LATENCY  = 39;
   localparam int WD_LIMIT = 4000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_data = '0;
   logic          rsp_strobe;
   rsp_type       rsp_data;
   logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [AW-1:0] paddr = '0;
   logic [DW-1:0] pwdata = '0;
   logic [DW-1:0] prdata;
   logic          pready;

   always #1 clock = ~clock;

   homogeneous_point_transform u_top (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // predictor copy of the matrix registers
   logic [63:0] mat_q [NREG];
   req_type     pending_pts [$];
   rsp_type     expected_pts [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   int          gap = 0;

   function automatic logic signed [63:0] coef_at(int row, int col);
      logic [63:0] r;
      r = mat_q[row * 2 + col / 2];
      return (col % 2) ? {{32{r[63]}}, r[63:32]} : {{32{r[31]}}, r[31:0]};
   endfunction

   // each product floored separately, low parts summed and carried in
   function automatic logic signed [95:0] row_dot(int row,
         logic signed [63:0] v [3], bit translate);
      logic signed [95:0] q;
      logic [95:0] lo_sum;
      logic signed [95:0] p;
      q = 0;
      lo_sum = 0;
      for (int c = 0; c < 3; c++) begin
         p = coef_at(row, c) * v[c];
         q += p >>> 16;
         lo_sum += p[15:0];
      end
      q += lo_sum >> 16;
      if (translate) q += coef_at(row, 3);
      return q;
   endfunction

   function automatic logic signed [95:0] fixed_quot(logic signed [95:0] num,
         logic signed [95:0] den);
      logic [127:0] m, d, qt;
      bit neg;
      neg = (num < 0) != (den < 0);
      m = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      qt = (m << 16) / d;
      if (qt > (128'd1 << 40)) qt = 128'd1 << 40;
      return neg ? -$signed({1'b0, qt[94:0]}) : $signed({1'b0, qt[94:0]});
   endfunction

   function automatic rsp_type transform_point(req_type t);
      logic signed [63:0] v [3];
      logic signed [95:0] res [3];
      logic signed [95:0] w;
      logic [31:0] o [3];
      bit sat;
      rsp_type r;
      v[0] = t.in_x; v[1] = t.in_y; v[2] = t.in_z;
      sat = 1'b0;
      r.status = STATUS_OK;
      for (int k = 0; k < 3; k++) res[k] = row_dot(k, v, !t.mode);
      if (!t.mode) begin
         w = row_dot(3, v, 1'b1);
         if (w == 0) begin
            r.status = STATUS_WZERO;
            for (int k = 0; k < 3; k++)
               res[k] = res[k] > 0 ? 96'sd2147483647 :
                        res[k] < 0 ? -96'sd2147483648 : 96'sd0;
         end else if (w != 96'sd65536) begin
            for (int k = 0; k < 3; k++) res[k] = fixed_quot(res[k], w);
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (res[k] > 96'sd2147483647) begin
            sat = 1'b1; o[k] = 32'h7FFFFFFF;
         end else if (res[k] < -96'sd2147483648) begin
            sat = 1'b1; o[k] = 32'h80000000;
         end else o[k] = res[k][31:0];
      end
      if (r.status == STATUS_OK && sat) r.status = STATUS_SAT;
      r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2];
      return r;
   endfunction

   // driver: one transaction per accepted start, random gap between them
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_pts.push_back(transform_point(req_data));
         gap = $urandom_range(0, 3);
         if (gap == 0 && !hold_off && pending_pts.size() > 0) begin
            req_data <= pending_pts.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap > 0) gap--;
         else if (!hold_off && pending_pts.size() > 0) begin
            req_data <= pending_pts.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor: responses cannot be held off, check on the strobe
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_pts.size() == 0) begin
            $error("unexpected transaction %h", rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_pts.pop_front();
            if (rsp_data.out_x !== e.out_x) begin
               $error("out_x exp %h got %h", e.out_x, rsp_data.out_x); errors++;
            end
            if (rsp_data.out_y !== e.out_y) begin
               $error("out_y exp %h got %h", e.out_y, rsp_data.out_y); errors++;
            end
            if (rsp_data.out_z !== e.out_z) begin
               $error("out_z exp %h got %h", e.out_z, rsp_data.out_z); errors++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no accepted request, no response and no config access
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("** homogeneous_point_transform: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(int idx, logic [63:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= AW'(idx * 8); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      mat_q[idx] = val;
   endtask

   task automatic drain();
      while (pending_pts.size() > 0 || start || expected_pts.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 1) ? 32'h00010000 : 32'h0;
         3: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
         default: return $urandom;
      endcase
   endfunction

   // Q16.16 coefficient: small values mostly, some wide and extreme
   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 6))
         0: return 32'h0;
         1: return 32'h00010000;
         2: return 32'h7FFFFFFF;
         3: return 32'h80000000;
         4: return $urandom;
         default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      endcase
   endfunction

   function automatic req_type rand_point();
      req_type t;
      t.mode = 1'($urandom_range(0, 1));
      t.in_x = rand_coord(); t.in_y = rand_coord(); t.in_z = rand_coord();
      return t;
   endfunction

   task automatic push_pt(bit m, logic [31:0] x, y, z);
      req_type t;
      t.mode = m; t.in_x = x; t.in_y = y; t.in_z = z;
      pending_pts.push_back(t);
   endtask

   initial begin
      // identity after reset
      mat_q[0] = 64'h10000;        mat_q[1] = 0;
      mat_q[2] = 64'h10000 << 32;  mat_q[3] = 0;
      mat_q[4] = 0;                mat_q[5] = 64'h10000;
      mat_q[6] = 0;                mat_q[7] = 64'h10000 << 32;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, extremes, both modes
      push_pt(0, 32'h00010000, 32'hFFFF0000, 32'h0);
      push_pt(1, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
      push_pt(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      push_pt(0, 32'h80000000, 32'h80000000, 32'h80000000);
      push_pt(0, 32'h0, 32'h0, 32'h0);
      drain();

      // scale by 2, translate, weight 2 so the divide path runs
      csr_write(0, {32'h0, 32'h00020000});
      csr_write(1, {32'h00050000, 32'h0});
      csr_write(2, {32'h00020000, 32'h0});
      csr_write(3, {32'hFFFB0000, 32'h0});
      csr_write(4, {32'h0, 32'h0});
      csr_write(5, {32'h00030000, 32'h00020000});
      csr_write(6, {32'h0, 32'h0});
      csr_write(7, {32'h00020000, 32'h0});
      push_pt(0, 32'h00010000, 32'h00020000, 32'hFFFF8000);
      push_pt(1, 32'h00010000, 32'h00020000, 32'hFFFF8000);
      push_pt(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      drain();

      // weight zero: row 3 all zero; signs of the numerators differ
      csr_write(7, 64'h0);
      push_pt(0, 32'h00010000, 32'hFFFF0000, 32'h0);
      push_pt(0, 32'h0, 32'h0, 32'h0);
      push_pt(1, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
      drain();

      // tiny weight gives huge quotients (quotient cap and clamp)
      csr_write(7, {32'h00000001, 32'h0});
      push_pt(0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000);
      push_pt(0, 32'h00000001, 32'hFFFFFFFF, 32'h0);
      drain();

      // random phases with random matrices, extremes among them
      for (int ph = 0; ph < 15; ph++) begin
         for (int i = 0; i < NREG; i++) begin
            logic [63:0] v;
            if (ph == 0) v = 64'hFFFFFFFFFFFFFFFF;
            else if (ph == 1) v = 64'h7FFFFFFF7FFFFFFF;
            else if (ph == 2) v = 64'h8000000080000000;
            else v = {rand_coef(), rand_coef()};
            // weight of exactly one stays common
            if (ph % 3 == 0 && i == 6) v = 64'h0;
            if (ph % 3 == 0 && i == 7) v = 64'h10000 << 32;
            csr_write(i, v);
         end
         for (int n = 0; n < 100; n++) pending_pts.push_back(rand_point());
         if (ph == 7) begin
            // hold off until the pipe is empty, then resume
            while (pending_pts.size() > 50) @(posedge clock);
            hold_off = 1'b1;
            while (start || expected_pts.size() > 0) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end

      if (errors == 0) $display("** homogeneous_point_transform: PASSED **");
      else $display("** homogeneous_point_transform: FAILED **");
      $finish;
   end
endmodule
